>>> rtl/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg: shared types and constants of the quadrature detent decoder
// phase codes, pin reading patterns and the per-sample step result
// ----------------------------------------------------------------------------
package qdd_pkg;

   localparam int IndexWidth           = 3;
   localparam int IndexCount           = 1 << IndexWidth;
   localparam int NumEncodersDefault   = 6;
   localparam int ReqDataWidth         = 8;
   localparam int RspDataWidth         = 8;

   typedef logic [1:0] reading_type;

   // reading is {pin_a, pin_b}
   localparam reading_type ReadBothHigh = 2'b11;
   localparam reading_type ReadBLow     = 2'b10;
   localparam reading_type ReadALow     = 2'b01;
   localparam reading_type ReadBothLow  = 2'b00;

   typedef enum logic [2:0] {
      PH_REST  = 3'd0,
      PH_CW_A  = 3'd1,
      PH_CW_B  = 3'd2,
      PH_CW_C  = 3'd3,
      PH_CCW_A = 3'd4,
      PH_CCW_B = 3'd5,
      PH_CCW_C = 3'd6
   } phase_type;

   typedef enum logic {
      DIR_CW  = 1'b0,
      DIR_CCW = 1'b1
   } direction_type;

   typedef struct packed {
      phase_type     phase;
      logic          emit;
      direction_type direction;
   } step_type;

endpackage

>>> rtl/quadrature_detent_decoder.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder: multi-channel rotary encoder detent decoder
// one pin sample per item; one result per completed detent with its direction
// ----------------------------------------------------------------------------
// Each item is a pin sample for one encoder. It is registered, then its
// encoder's phase and previous reading are read, stepped and written back
// when the output register can take a result, and a detent result lands
// there. An item is taken every cycle while results are taken; a sample's
// result is offered from the output register, which follows the input
// register. Samples whose encoder index is not below NUM_ENCODERS are
// dropped with no effect. At most eight encoders are held, set by the 3-bit index.
module quadrature_detent_decoder #(
   parameter int NUM_ENCODERS = qdd_pkg::NumEncodersDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] encoder_index, [3] pin_a, [4] pin_b, [7:5] zero
   input  logic [qdd_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] event_encoder, [3] direction, [7:4] zero
   output logic [qdd_pkg::RspDataWidth-1:0]  rsp_tdata
);

   localparam int NumSlots = (NUM_ENCODERS < qdd_pkg::IndexCount) ?
                             NUM_ENCODERS : qdd_pkg::IndexCount;

   logic                               s1_valid_ff;
   logic [qdd_pkg::IndexWidth-1:0]     s1_index_ff;
   qdd_pkg::reading_type               s1_reading_ff;

   qdd_pkg::phase_type                 phase_ff   [NumSlots];
   qdd_pkg::reading_type               prev_ff    [NumSlots];

   logic                               rsp_valid_ff;
   logic [qdd_pkg::IndexWidth-1:0]     rsp_encoder_ff;
   qdd_pkg::direction_type             rsp_direction_ff;

   logic                               advance;
   logic                               hit;
   qdd_pkg::phase_type                 sel_phase;
   qdd_pkg::reading_type               sel_prev;
   qdd_pkg::step_type                  step;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // select the state of the sampled encoder
   always_comb begin
      hit       = 1'b0;
      sel_phase = qdd_pkg::PH_REST;
      sel_prev  = qdd_pkg::ReadBothHigh;
      for (int i = 0; i < NumSlots; i++) begin
         if (s1_index_ff == qdd_pkg::IndexWidth'(i)) begin
            hit       = 1'b1;
            sel_phase = phase_ff[i];
            sel_prev  = prev_ff[i];
         end
      end
   end

   qdd_step u_step (
      .phase        (sel_phase),
      .prev_reading (sel_prev),
      .cur_reading  (s1_reading_ff),
      .step         (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_index_ff   <= req_tdata[qdd_pkg::IndexWidth-1:0];
         s1_reading_ff <= {req_tdata[3], req_tdata[4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSlots; i++) begin
            phase_ff[i] <= qdd_pkg::PH_REST;
            prev_ff[i]  <= qdd_pkg::ReadBothHigh;
         end
      end else if (advance) begin
         for (int i = 0; i < NumSlots; i++) begin
            if (s1_index_ff == qdd_pkg::IndexWidth'(i)) begin
               phase_ff[i] <= step.phase;
               prev_ff[i]  <= s1_reading_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= hit && step.emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_encoder_ff   <= s1_index_ff;
         rsp_direction_ff <= step.direction;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_direction_ff, rsp_encoder_ff};

endmodule

>>> rtl/qdd_step.sv
// ----------------------------------------------------------------------------
// qdd_step: phase walk of one encoder
// next phase and detent event from the stored phase, previous and current reading
// ----------------------------------------------------------------------------
module qdd_step (
   input  qdd_pkg::phase_type   phase,
   input  qdd_pkg::reading_type prev_reading,
   input  qdd_pkg::reading_type cur_reading,
   output qdd_pkg::step_type    step
);

   always_comb begin
      step.phase     = phase;
      step.emit      = 1'b0;
      step.direction = qdd_pkg::DIR_CW;
      unique case (phase)
         qdd_pkg::PH_REST: begin
            if (prev_reading == qdd_pkg::ReadBothHigh) begin
               priority if (!cur_reading[1]) step.phase = qdd_pkg::PH_CCW_A;
               else if (!cur_reading[0])     step.phase = qdd_pkg::PH_CW_A;
               else                          step.phase = qdd_pkg::PH_REST;
            end
         end
         qdd_pkg::PH_CW_A: begin
            if (prev_reading == qdd_pkg::ReadBLow) begin
               priority if (cur_reading == qdd_pkg::ReadBothLow) step.phase = qdd_pkg::PH_CW_B;
               else if (cur_reading == qdd_pkg::ReadBLow)        step.phase = qdd_pkg::PH_CW_A;
               else                                              step.phase = qdd_pkg::PH_REST;
            end
         end
         qdd_pkg::PH_CCW_A: begin
            if (prev_reading == qdd_pkg::ReadALow) begin
               priority if (cur_reading == qdd_pkg::ReadBothLow) step.phase = qdd_pkg::PH_CCW_B;
               else if (cur_reading == qdd_pkg::ReadALow)        step.phase = qdd_pkg::PH_CCW_A;
               else                                              step.phase = qdd_pkg::PH_REST;
            end
         end
         qdd_pkg::PH_CW_B: begin
            if (prev_reading == qdd_pkg::ReadBothLow) begin
               priority if (cur_reading == qdd_pkg::ReadALow) step.phase = qdd_pkg::PH_CW_C;
               else if (cur_reading == qdd_pkg::ReadBothLow)  step.phase = qdd_pkg::PH_CW_B;
               else                                           step.phase = qdd_pkg::PH_REST;
            end
         end
         qdd_pkg::PH_CCW_B: begin
            if (prev_reading == qdd_pkg::ReadBothLow) begin
               priority if (cur_reading == qdd_pkg::ReadBLow) step.phase = qdd_pkg::PH_CCW_C;
               else if (cur_reading == qdd_pkg::ReadBothLow)  step.phase = qdd_pkg::PH_CCW_B;
               else                                           step.phase = qdd_pkg::PH_REST;
            end
         end
         qdd_pkg::PH_CW_C: begin
            if (prev_reading == qdd_pkg::ReadALow) begin
               priority if (cur_reading == qdd_pkg::ReadBothHigh) begin
                  step.emit      = 1'b1;
                  step.direction = qdd_pkg::DIR_CW;
                  step.phase     = qdd_pkg::PH_REST;
               end else if (cur_reading == qdd_pkg::ReadALow) begin
                  step.phase = qdd_pkg::PH_CW_C;
               end else begin
                  step.phase = qdd_pkg::PH_REST;
               end
            end
         end
         qdd_pkg::PH_CCW_C: begin
            if (prev_reading == qdd_pkg::ReadBLow) begin
               priority if (cur_reading == qdd_pkg::ReadBothHigh) begin
                  step.emit      = 1'b1;
                  step.direction = qdd_pkg::DIR_CCW;
                  step.phase     = qdd_pkg::PH_REST;
               end else if (cur_reading == qdd_pkg::ReadBLow) begin
                  step.phase = qdd_pkg::PH_CCW_C;
               end else begin
                  step.phase = qdd_pkg::PH_REST;
               end
            end
         end
         default: begin
            step.phase = phase;
         end
      endcase
   end

endmodule
